/* hw/rtl/tkf_pkg.sv */
// Shared types and constants of the two-axis tilt filter.
`timescale 1ns / 1ps

package tkf_pkg;

  localparam int RATE_W     = 18;
  localparam int ANGLE_W    = 17;
  localparam int VAR_W      = 32;
  localparam int STEP_W     = 16;
  localparam int NOISE_W    = 24;
  localparam int STEP_FRAC  = 16;
  localparam int ANGLE_LIMIT = 46080;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STEP_TIME         = 3'd0,
    REG_PROCESS_NOISE     = 3'd1,
    REG_MEASUREMENT_NOISE = 3'd2,
    REG_ROLL_RATE_OFFSET  = 3'd3,
    REG_PITCH_RATE_OFFSET = 3'd4
  } tkf_reg_t;

  typedef struct packed {
    logic [STEP_W-1:0]  step_time;
    logic [NOISE_W-1:0] process_noise;
    logic [NOISE_W-1:0] measurement_noise;
  } tkf_cfg_t;

  typedef struct packed {
    logic start;
    logic ack;
  } tkf_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } tkf_stat_t;

endpackage

/* hw/rtl/tkf_divider.sv */
// Restoring divider for the Kalman gain, one quotient bit per cycle.
`timescale 1ns / 1ps

module tkf_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          num,
  input  logic [32:0]          den,
  output logic                 done,
  output logic [FRAC_BITS:0]   quotient
);

  localparam int REM_W = 34;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  typedef enum logic {D_IDLE, D_RUN} div_state_t;

  div_state_t            state_r, state_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [32:0]           den_r, den_nxt;
  logic [FRAC_BITS:0]    q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  zero_r, zero_nxt;
  logic                  done_r, done_nxt;

  logic [REM_W-1:0]      trial;
  logic [REM_W-1:0]      diff;
  logic                  ge;

  always_comb begin
    trial = (cnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
    ge    = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          rem_nxt   = {2'b00, num};
          den_nxt   = den;
          zero_nxt  = (den == '0);
          cnt_nxt   = '0;
          q_nxt     = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? diff : trial;
        q_nxt   = {q_r[FRAC_BITS-1:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    zero_r <= zero_nxt;
  end

  assign done     = done_r;
  assign quotient = zero_r ? '0 : q_r;

endmodule

/* hw/rtl/tkf_lane.sv */
// One axis of the filter: predict, gain, correct, with its stored estimate.
`timescale 1ns / 1ps

module tkf_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tkf_pkg::tkf_cfg_t                  cfg,
  input  logic signed [tkf_pkg::RATE_W-1:0]  rate_offset,
  input  tkf_pkg::tkf_ctl_t                  ctl,
  input  logic signed [tkf_pkg::RATE_W-1:0]  rate,
  input  logic signed [tkf_pkg::ANGLE_W-1:0] measured,
  output tkf_pkg::tkf_stat_t                 stat,
  output logic signed [tkf_pkg::ANGLE_W-1:0] angle,
  output logic [tkf_pkg::VAR_W-1:0]          variance
);

  localparam int PR_W  = 36;
  localparam int ADV_W = 20;
  localparam int PD_W  = 21;
  localparam int IN_W  = 22;
  localparam int PA_W  = FRAC_BITS + 24;
  localparam int ADJ_W = PA_W - FRAC_BITS;
  localparam int SUM_W = 25;
  localparam int PV_W  = FRAC_BITS + 33;
  localparam logic [31:0] VAR_RESET = 32'd4 << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(tkf_pkg::ANGLE_LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_LO = -SUM_W'(tkf_pkg::ANGLE_LIMIT);

  typedef enum logic [2:0] {
    L_IDLE, L_ADV, L_PRED, L_DIV, L_MULA, L_MULV, L_FIN, L_DONE
  } lane_state_t;

  lane_state_t                state_r, state_nxt;
  logic signed [18:0]         rate_r, rate_nxt;
  logic signed [16:0]         meas_r, meas_nxt;
  logic signed [PR_W-1:0]     prod_r_r, prod_r_nxt;
  logic signed [PD_W-1:0]     pred_r, pred_nxt;
  logic [31:0]                p_r, p_nxt;
  logic [FRAC_BITS:0]         k_r, k_nxt;
  logic signed [PA_W-1:0]     prod_a_r, prod_a_nxt;
  logic [PV_W-1:0]            prod_v_r, prod_v_nxt;
  logic signed [16:0]         est_r, est_nxt;
  logic [31:0]                var_r, var_nxt;
  logic                       div_start_r, div_start_nxt;

  logic signed [PR_W-1:0]     rate_ext, step_ext, adv_sum;
  logic signed [ADV_W-1:0]    adv;
  logic [32:0]                psum;
  logic [32:0]                den;
  logic signed [IN_W-1:0]     innov;
  logic signed [PA_W-1:0]     k_ext, innov_ext, adj_sum;
  logic signed [ADJ_W-1:0]    adj;
  logic signed [SUM_W-1:0]    corr;
  logic [FRAC_BITS:0]         gain_c;
  logic [PV_W-1:0]            var_sum;
  logic                       div_done;
  logic [FRAC_BITS:0]         div_q;

  always_comb begin
    rate_ext  = {{(PR_W-19){rate_r[18]}}, rate_r};
    step_ext  = $signed({{(PR_W-tkf_pkg::STEP_W){1'b0}}, cfg.step_time});
    adv_sum   = prod_r_r + (PR_W'(1) <<< (tkf_pkg::STEP_FRAC - 1));
    adv       = adv_sum[PR_W-1:tkf_pkg::STEP_FRAC];
    psum      = {1'b0, var_r} + {9'd0, cfg.process_noise};
    den       = {1'b0, p_r} + {9'd0, cfg.measurement_noise};
    innov     = {{(IN_W-17){meas_r[16]}}, meas_r} - {{(IN_W-PD_W){pred_r[PD_W-1]}}, pred_r};
    k_ext     = $signed({{(PA_W-FRAC_BITS-1){1'b0}}, k_r});
    innov_ext = {{(PA_W-IN_W){innov[IN_W-1]}}, innov};
    adj_sum   = prod_a_r + (PA_W'(1) <<< (FRAC_BITS - 1));
    adj       = adj_sum[PA_W-1:FRAC_BITS];
    corr      = {{(SUM_W-PD_W){pred_r[PD_W-1]}}, pred_r}
              + {{(SUM_W-ADJ_W){adj[ADJ_W-1]}}, adj};
    gain_c    = {1'b1, {FRAC_BITS{1'b0}}} - k_r;
    var_sum   = prod_v_r + (PV_W'(1) << (FRAC_BITS - 1));
  end

  always_comb begin
    state_nxt     = state_r;
    rate_nxt      = rate_r;
    meas_nxt      = meas_r;
    prod_r_nxt    = prod_r_r;
    pred_nxt      = pred_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    prod_a_nxt    = prod_a_r;
    prod_v_nxt    = prod_v_r;
    est_nxt       = est_r;
    var_nxt       = var_r;
    div_start_nxt = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (ctl.start) begin
          rate_nxt  = {rate[tkf_pkg::RATE_W-1], rate}
                    - {rate_offset[tkf_pkg::RATE_W-1], rate_offset};
          meas_nxt  = measured;
          state_nxt = L_ADV;
        end
      end
      L_ADV: begin
        prod_r_nxt = rate_ext * step_ext;
        state_nxt  = L_PRED;
      end
      L_PRED: begin
        pred_nxt      = {{(PD_W-17){est_r[16]}}, est_r} + {adv[ADV_W-1], adv};
        p_nxt         = psum[32] ? 32'hFFFF_FFFF : psum[31:0];
        div_start_nxt = 1'b1;
        state_nxt     = L_DIV;
      end
      L_DIV: begin
        if (div_done) begin
          k_nxt     = div_q;
          state_nxt = L_MULA;
        end
      end
      L_MULA: begin
        prod_a_nxt = k_ext * innov_ext;
        state_nxt  = L_MULV;
      end
      L_MULV: begin
        prod_v_nxt = PV_W'(gain_c) * PV_W'(p_r);
        state_nxt  = L_FIN;
      end
      L_FIN: begin
        if (corr > LIM_HI) begin
          est_nxt = LIM_HI[16:0];
        end else if (corr < LIM_LO) begin
          est_nxt = LIM_LO[16:0];
        end else begin
          est_nxt = corr[16:0];
        end
        var_nxt   = var_sum[FRAC_BITS+31:FRAC_BITS];
        state_nxt = L_DONE;
      end
      L_DONE: begin
        if (ctl.ack) begin
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= L_IDLE;
      div_start_r <= 1'b0;
      est_r       <= '0;
      var_r       <= VAR_RESET;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
    end
    rate_r   <= rate_nxt;
    meas_r   <= meas_nxt;
    prod_r_r <= prod_r_nxt;
    pred_r   <= pred_nxt;
    p_r      <= p_nxt;
    k_r      <= k_nxt;
    prod_a_r <= prod_a_nxt;
    prod_v_r <= prod_v_nxt;
  end

  tkf_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .num      (p_r),
    .den      (den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.idle = (state_r == L_IDLE);
  assign stat.done = (state_r == L_DONE);
  assign angle     = est_r;
  assign variance  = var_r;

endmodule

/* hw/rtl/dual_axis_tilt_kalman_filter.sv */
// Top level: register port, per-axis filter lanes and result merge stage.
`timescale 1ns / 1ps

// Two-axis tilt filter: one scalar Kalman filter per axis (roll, pitch), each in
// its own lane, both lanes running in parallel on every item. Each lane's gain
// divider yields one quotient bit per cycle. A new item is accepted once both
// lanes have handed their result to the output register, so one result may
// wait on out_tready while the next item runs.
// Axes at or above AXIS_COUNT keep their reset estimate and variance.
module dual_axis_tilt_kalman_filter #(
  parameter int AXIS_COUNT             = 2,
  parameter int VARIANCE_FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // roll_rate[17:0], pitch_rate[35:18], roll_measured[52:36], pitch_measured[69:53]
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // roll_angle[16:0], pitch_angle[33:17], roll_variance[65:34], pitch_variance[97:66]
  output logic [103:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int LANES = (AXIS_COUNT > 2) ? 2 : AXIS_COUNT;
  localparam logic [31:0] VAR_RESET = 32'd4 << VARIANCE_FRACTION_BITS;

  logic [15:0]        step_time_r;
  logic [23:0]        process_noise_r;
  logic [23:0]        measurement_noise_r;
  logic signed [17:0] roll_offset_r;
  logic signed [17:0] pitch_offset_r;

  logic                     out_valid_r;
  logic signed [16:0]       out_angle_r [2];
  logic [31:0]              out_var_r   [2];

  logic [2:0]               cfg_idx;
  logic                     cfg_wr;
  tkf_pkg::tkf_cfg_t        lane_cfg;
  tkf_pkg::tkf_ctl_t        lane_ctl;
  tkf_pkg::tkf_stat_t       lane_stat [2];
  logic signed [17:0]       lane_rate   [2];
  logic signed [16:0]       lane_meas   [2];
  logic signed [17:0]       lane_offset [2];
  logic signed [16:0]       lane_angle  [2];
  logic [31:0]              lane_var    [2];
  logic                     all_idle;
  logic                     all_done;
  logic                     load;

  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r         <= 16'd655;
      process_noise_r     <= 24'd655;
      measurement_noise_r <= 24'd65536;
      roll_offset_r       <= '0;
      pitch_offset_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tkf_pkg::REG_STEP_TIME:         step_time_r         <= cfg_pwdata[15:0];
        tkf_pkg::REG_PROCESS_NOISE:     process_noise_r     <= cfg_pwdata[23:0];
        tkf_pkg::REG_MEASUREMENT_NOISE: measurement_noise_r <= cfg_pwdata[23:0];
        tkf_pkg::REG_ROLL_RATE_OFFSET:  roll_offset_r       <= cfg_pwdata[17:0];
        tkf_pkg::REG_PITCH_RATE_OFFSET: pitch_offset_r      <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tkf_pkg::REG_STEP_TIME:         cfg_prdata = {16'd0, step_time_r};
      tkf_pkg::REG_PROCESS_NOISE:     cfg_prdata = {8'd0, process_noise_r};
      tkf_pkg::REG_MEASUREMENT_NOISE: cfg_prdata = {8'd0, measurement_noise_r};
      tkf_pkg::REG_ROLL_RATE_OFFSET:  cfg_prdata = {14'd0, roll_offset_r};
      tkf_pkg::REG_PITCH_RATE_OFFSET: cfg_prdata = {14'd0, pitch_offset_r};
      default:                        cfg_prdata = '0;
    endcase
  end

  assign lane_cfg.step_time         = step_time_r;
  assign lane_cfg.process_noise     = process_noise_r;
  assign lane_cfg.measurement_noise = measurement_noise_r;

  assign lane_rate[0]   = in_tdata[17:0];
  assign lane_rate[1]   = in_tdata[35:18];
  assign lane_meas[0]   = in_tdata[52:36];
  assign lane_meas[1]   = in_tdata[69:53];
  assign lane_offset[0] = roll_offset_r;
  assign lane_offset[1] = pitch_offset_r;

  assign all_idle       = lane_stat[0].idle & lane_stat[1].idle;
  assign all_done       = lane_stat[0].done & lane_stat[1].done;
  assign load           = all_done & (~out_valid_r | out_tready);
  assign in_tready      = all_idle;
  assign lane_ctl.start = in_tvalid & all_idle;
  assign lane_ctl.ack   = load;

  for (genvar a = 0; a < 2; a++) begin : g_axis
    if (a < LANES) begin : g_lane
      tkf_lane #(
        .FRAC_BITS (VARIANCE_FRACTION_BITS)
      ) u_lane (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (lane_cfg),
        .rate_offset (lane_offset[a]),
        .ctl         (lane_ctl),
        .rate        (lane_rate[a]),
        .measured    (lane_meas[a]),
        .stat        (lane_stat[a]),
        .angle       (lane_angle[a]),
        .variance    (lane_var[a])
      );
    end else begin : g_fixed
      assign lane_stat[a].idle = 1'b1;
      assign lane_stat[a].done = 1'b1;
      assign lane_angle[a]     = '0;
      assign lane_var[a]       = VAR_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (load) begin
      out_angle_r[0] <= lane_angle[0];
      out_angle_r[1] <= lane_angle[1];
      out_var_r[0]   <= lane_var[0];
      out_var_r[1]   <= lane_var[1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_var_r[1], out_var_r[0], out_angle_r[1], out_angle_r[0]};

endmodule
